// ----- hdl/tagged_chunk_extractor_macros.svh -----
// Assertion macros shared by the tagged chunk extractor modules.
// Each macro expects the including module to have clk and rst_n in scope.
`ifndef TAGGED_CHUNK_EXTRACTOR_MACROS_SVH
`define TAGGED_CHUNK_EXTRACTOR_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define TCE_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after the condition.
`define TCE_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/tce_pkg.sv -----
// Package of the tagged chunk extractor: buffer sizing, result codes,
// item structs and the command and status structs of controller and datapath.
package tce_pkg;

    localparam int BUFFER_DEPTH = 128;
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = CW + 2;

    localparam logic [7:0] MAGIC_O = 8'h4F;
    localparam logic [7:0] MAGIC_F = 8'h46;
    localparam logic [7:0] MAGIC_ONE = 8'h31;
    localparam logic [7:0] HEADER_BYTES = 8'd8;
    localparam logic [7:0] MIN_SCRIPT = 8'd9;
    localparam logic [7:0] TEXT_CAP = 8'd120;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    localparam logic [1:0] STATUS_FOUND = 2'd0;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] script_byte;
        logic       end_of_script;
    } tce_in_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [31:0] chunk_index;
        logic [31:0] text_word;
        logic [2:0]  text_count;
        logic        run_last;
    } tce_out_t;

    typedef struct packed {
        logic write;
        logic finish;
        logic run;
        logic latch_match;
        logic index_take;
        logic text_take;
        logic emit_overflow;
        logic emit_no_match;
    } tce_cmd_t;

    typedef struct packed {
        logic dv;
        logic overflow_now;
        logic short_now;
        logic match;
        logic scan_end;
        logic index_last;
        logic text_empty;
        logic text_last;
    } tce_sts_t;

endpackage

// ----- hdl/tce_controller.sv -----
// Controller state machine of the tagged chunk extractor.
// Depends on tce_pkg and drives the datapath through tce_cmd_t.
`include "tagged_chunk_extractor_macros.svh"

module tce_controller
    import tce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     end_of_script,
    input  tce_sts_t sts,
    output tce_cmd_t cmd,
    output logic     busy
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_INDEX = 4'b0100,
        ST_TEXT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.write = 1'b1;
                    if (end_of_script)
                    begin
                        cmd.finish = 1'b1;
                        if (sts.overflow_now)
                        begin
                            cmd.emit_overflow = 1'b1;
                        end
                        else if (sts.short_now)
                        begin
                            cmd.emit_no_match = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.run = 1'b1;
                if (sts.dv)
                begin
                    if (sts.match)
                    begin
                        cmd.latch_match = 1'b1;
                        state_next = ST_INDEX;
                    end
                    else if (sts.scan_end)
                    begin
                        cmd.emit_no_match = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_INDEX:
            begin
                cmd.run = 1'b1;
                if (sts.dv)
                begin
                    cmd.index_take = 1'b1;
                    if (sts.index_last)
                    begin
                        state_next = sts.text_empty ? ST_IDLE : ST_TEXT;
                    end
                end
            end
            ST_TEXT:
            begin
                cmd.run = 1'b1;
                if (sts.dv)
                begin
                    cmd.text_take = 1'b1;
                    if (sts.text_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TCE_ASSERT_NOW(a_stream_gapless, (state_reg == ST_INDEX) || (state_reg == ST_TEXT), sts.dv, "read stream gap after a match")
    `TCE_ASSERT_NEXT(a_scan_entry, (state_reg == ST_IDLE) && start && end_of_script && !sts.overflow_now && !sts.short_now, state_reg == ST_SCAN, "long script did not start a scan")

endmodule

// ----- hdl/tce_datapath.sv -----
// Datapath of the tagged chunk extractor: script buffer, read stream,
// magic window, index and text assembly and the result register. Uses tce_pkg.
`include "tagged_chunk_extractor_macros.svh"

module tce_datapath
    import tce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tce_in_t  data,
    input  tce_cmd_t cmd,
    output tce_sts_t sts,
    output logic     strobe,
    output tce_out_t result
);

    logic [7:0]    mem [BUFFER_DEPTH];

    logic [CW-1:0] byte_count_reg;
    logic          overflowed_reg;
    logic [CW-1:0] len_reg;
    logic [AW-1:0] ra_reg;
    logic [AW-1:0] da_reg;
    logic          dv_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    h0_reg;
    logic [7:0]    h1_reg;
    logic [7:0]    h2_reg;
    logic [7:0]    h3_reg;
    logic [1:0]    icnt_reg;
    logic [31:0]   idx_reg;
    logic [7:0]    rem_reg;
    logic [1:0]    lane_reg;
    logic [31:0]   word_reg;
    logic          strobe_reg;
    logic          strobe_next;
    tce_out_t      result_reg;
    tce_out_t      result_next;

    logic          full;
    logic [CW:0]   count_plus;
    logic [SW-1:0] reach;
    logic [SW-1:0] limit;
    logic [7:0]    text_len;
    logic [31:0]   word_cur;
    logic          text_emit;

    assign full = (byte_count_reg == CW'(BUFFER_DEPTH));
    assign count_plus = {1'b0, byte_count_reg} + (CW + 1)'(1);
    assign reach = SW'(da_reg) + SW'(h3_reg);
    assign limit = SW'(len_reg) + SW'(3);
    assign text_len = ((h3_reg - HEADER_BYTES) > TEXT_CAP) ? TEXT_CAP : (h3_reg - HEADER_BYTES);
    assign word_cur = word_reg | ({24'd0, rd_data_reg} << {lane_reg, 3'b000});
    assign text_emit = (lane_reg == 2'd3) || (rem_reg == 8'd1);

    always_comb
    begin
        sts.dv = dv_reg;
        sts.overflow_now = overflowed_reg || full;
        sts.short_now = (count_plus < (CW + 1)'(MIN_SCRIPT));
        sts.match = dv_reg && (da_reg >= AW'(4)) && (h2_reg == MAGIC_O) &&
                    (h1_reg == MAGIC_F) && (h0_reg == MAGIC_F) &&
                    (rd_data_reg == MAGIC_ONE) && (h3_reg >= HEADER_BYTES) &&
                    (reach <= limit);
        sts.scan_end = ((SW'(da_reg) + SW'(5)) == SW'(len_reg));
        sts.index_last = (icnt_reg == 2'd3);
        sts.text_empty = (rem_reg == 8'd0);
        sts.text_last = (rem_reg == 8'd1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && !full)
        begin
            mem[byte_count_reg[AW-1:0]] <= data.script_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.run)
        begin
            rd_data_reg <= mem[ra_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            overflowed_reg <= 1'b0;
            len_reg <= '0;
            ra_reg <= '0;
            da_reg <= '0;
            dv_reg <= 1'b0;
            icnt_reg <= '0;
            rem_reg <= '0;
            lane_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                byte_count_reg <= '0;
                overflowed_reg <= 1'b0;
                len_reg <= count_plus[CW-1:0];
            end
            else if (cmd.write)
            begin
                if (full)
                begin
                    overflowed_reg <= 1'b1;
                end
                else
                begin
                    byte_count_reg <= count_plus[CW-1:0];
                end
            end

            if (cmd.finish)
            begin
                ra_reg <= '0;
            end
            else if (cmd.run)
            begin
                ra_reg <= ra_reg + AW'(1);
            end
            dv_reg <= cmd.run;
            if (cmd.run)
            begin
                da_reg <= ra_reg;
            end

            if (cmd.latch_match)
            begin
                icnt_reg <= '0;
                lane_reg <= '0;
                rem_reg <= text_len;
            end
            else
            begin
                if (cmd.index_take)
                begin
                    icnt_reg <= icnt_reg + 2'd1;
                end
                if (cmd.text_take)
                begin
                    lane_reg <= lane_reg + 2'd1;
                    rem_reg <= rem_reg - 8'd1;
                end
            end

            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_reg)
        begin
            h0_reg <= rd_data_reg;
            h1_reg <= h0_reg;
            h2_reg <= h1_reg;
            h3_reg <= h2_reg;
        end
        if (cmd.index_take)
        begin
            idx_reg <= {rd_data_reg, idx_reg[31:8]};
        end
        if (cmd.latch_match || (cmd.text_take && text_emit))
        begin
            word_reg <= '0;
        end
        else if (cmd.text_take)
        begin
            word_reg <= word_cur;
        end
        result_reg <= result_next;
    end

    always_comb
    begin
        result_next = '0;
        strobe_next = 1'b0;
        if (cmd.emit_overflow)
        begin
            strobe_next = 1'b1;
            result_next.kind = KIND_HEADER;
            result_next.status = STATUS_OVERFLOW;
            result_next.run_last = 1'b1;
        end
        else if (cmd.emit_no_match)
        begin
            strobe_next = 1'b1;
            result_next.kind = KIND_HEADER;
            result_next.status = STATUS_NO_MATCH;
            result_next.run_last = 1'b1;
        end
        else if (cmd.index_take && sts.index_last)
        begin
            strobe_next = 1'b1;
            result_next.kind = KIND_HEADER;
            result_next.status = STATUS_FOUND;
            result_next.chunk_index = {rd_data_reg, idx_reg[31:8]};
            result_next.run_last = sts.text_empty;
        end
        else if (cmd.text_take && text_emit)
        begin
            strobe_next = 1'b1;
            result_next.kind = KIND_TEXT;
            result_next.status = STATUS_FOUND;
            result_next.text_word = word_cur;
            result_next.text_count = {1'b0, lane_reg} + 3'd1;
            result_next.run_last = sts.text_last;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    `TCE_ASSERT_NOW(a_failed_header_last, strobe_reg && (result_reg.kind == KIND_HEADER) && (result_reg.status != STATUS_FOUND), result_reg.run_last, "failed header is not the final result")
    `TCE_ASSERT_NOW(a_text_shape, strobe_reg && (result_reg.kind == KIND_TEXT), (result_reg.text_count != 3'd0) && (result_reg.text_count <= 3'd4) && (result_reg.chunk_index == 32'd0), "malformed text result")

endmodule

// ----- hdl/tagged_chunk_extractor.sv -----
// Tagged chunk extractor: one script byte per cycle is taken while idle; after the last byte
// the buffer is read one position per cycle over its single read port, and results come out
// inline with that stream. A result is registered and shows on its strobe in the cycle
// after it is formed. Reset is asynchronous and active low; it clears counters, flags and
// the state machine, while the buffer contents are not reset. The receiver cannot stall
// the block.
module tagged_chunk_extractor
    import tce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  tce_in_t  data,
    output logic     strobe,
    output tce_out_t result
);

    tce_cmd_t cmd;
    tce_sts_t sts;

    tce_controller u_controller (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .end_of_script (data.end_of_script),
        .sts           (sts),
        .cmd           (cmd),
        .busy          (busy)
    );

    tce_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data),
        .cmd    (cmd),
        .sts    (sts),
        .strobe (strobe),
        .result (result)
    );

endmodule
